// ----- hw/rtl/ranked_chunk_work_dispenser_defines.svh -----
// Assertion macros for the chunk dispenser RTL.
`ifndef RANKED_CHUNK_WORK_DISPENSER_DEFINES_SVH
`define RANKED_CHUNK_WORK_DISPENSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define RCWD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define RCWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rcwd_pkg.sv -----
// Shared types and constants for the ranked chunk work dispenser.
`default_nettype none

package rcwd_pkg;

  // Field and register widths.
  localparam int unsigned DataW     = 32;
  localparam int unsigned PosW      = DataW + 1;
  localparam int unsigned DevW      = 7;
  localparam int unsigned RankMapW  = 8;
  localparam int unsigned RankW     = 2;
  localparam int unsigned GroupW    = 2;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned ApbDataW  = 32;

  // Default queue depth.
  localparam int unsigned NumGroupsDef = 4;

  // Register reset values.
  localparam logic [DataW-1:0]    RangeFirstRst  = '0;
  localparam logic [DataW-1:0]    RangeLastRst   = '0;
  localparam logic [DevW-1:0]     DeviceCountRst = DevW'(1);
  localparam logic [RankMapW-1:0] RankMapRst     = RankMapW'(228);

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_RANGE_FIRST  = 2'd0,
    REG_RANGE_LAST   = 2'd1,
    REG_DEVICE_COUNT = 2'd2,
    REG_RANK_MAP     = 2'd3
  } reg_idx_e;

  // Input action codes.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_GET   = 1'b1
  } action_e;

  // Configuration register contents.
  typedef struct packed {
    logic [DataW-1:0]    range_first;
    logic [DataW-1:0]    range_last;
    logic [DevW-1:0]     device_count;
    logic [RankMapW-1:0] rank_map;
  } cfg_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rcwd_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module rcwd_div #(
  parameter int unsigned DividendW = rcwd_pkg::PosW,
  parameter int unsigned DivisorW  = rcwd_pkg::DevW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic [DividendW-1:0]      quotient_o,
  output rcwd_pkg::div_stat_t       stat_o
);
  import rcwd_pkg::*;

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  rem_q;
  logic [CntW-1:0]      cnt_q;
  logic                 done_q;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 ge;

  // Trial subtraction of the divisor from the partial remainder.
  always_comb begin
    trial = {rem_q, quo_q[DividendW-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
  end

  // Dividend bits shift out as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DividendW-2:0], ge};
      rem_q <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(DividendW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rcwd_cfg.sv -----
// APB configuration registers of the chunk dispenser.
`default_nettype none

module rcwd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rcwd_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [rcwd_pkg::ApbDataW-1:0] pwdata,
  output logic [rcwd_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  output rcwd_pkg::cfg_t                     cfg_o
);
  import rcwd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_first  <= RangeFirstRst;
      cfg_q.range_last   <= RangeLastRst;
      cfg_q.device_count <= DeviceCountRst;
      cfg_q.rank_map     <= RankMapRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RANGE_FIRST:  cfg_q.range_first  <= pwdata[DataW-1:0];
        REG_RANGE_LAST:   cfg_q.range_last   <= pwdata[DataW-1:0];
        REG_DEVICE_COUNT: cfg_q.device_count <= pwdata[DevW-1:0];
        REG_RANK_MAP:     cfg_q.rank_map     <= pwdata[RankMapW-1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      REG_RANGE_FIRST:  prdata = ApbDataW'(cfg_q.range_first);
      REG_RANGE_LAST:   prdata = ApbDataW'(cfg_q.range_last);
      REG_DEVICE_COUNT: prdata = ApbDataW'(cfg_q.device_count);
      REG_RANK_MAP:     prdata = ApbDataW'(cfg_q.rank_map);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ranked_chunk_work_dispenser.sv -----
// Top level: chunk queue, sequencer and shared serial divider.
// Get transaction: the result is strobed in the cycle after acceptance; a refill keeps the block
// busy while the 33-step serial divider runs, and without a refill the block stays idle.
// Start transaction: each queue entry is filled in turn through ST_FILL_NEXT and ST_FILL_WAIT;
// the result comes when all k = NUM_GROUPS entries fill, or from ST_FILL_NEXT when the range runs out or is empty.
// Results are strobed for one cycle on done_o and cannot be stalled; reset is asynchronous,
// active low, and clears valid flags, next index and registers.
`default_nettype none
`include "ranked_chunk_work_dispenser_defines.svh"

module ranked_chunk_work_dispenser #(
  parameter int unsigned NUM_GROUPS = rcwd_pkg::NumGroupsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rcwd_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [rcwd_pkg::ApbDataW-1:0] pwdata,
  output logic [rcwd_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          action_i,
  input  wire logic [rcwd_pkg::GroupW-1:0]   group_id_i,
  output logic [rcwd_pkg::DataW-1:0]         chunk_first_o,
  output logic [rcwd_pkg::DataW-1:0]         chunk_last_o,
  output logic                               had_work_o,
  output logic                               done_o
);
  import rcwd_pkg::*;

  localparam int unsigned IdxW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL_NEXT,
    ST_FILL_WAIT,
    ST_GET_WAIT
  } state_e;

  state_e              state_q;
  cfg_t                cfg;
  div_stat_t           div_stat;
  logic [PosW-1:0]     quotient;
  logic [DevW-1:0]     divisor;
  logic [PosW-1:0]     remaining;
  logic                div_go;

  logic [DataW-1:0]    qf_q [NUM_GROUPS];
  logic [DataW-1:0]    ql_q [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] valid_q;
  logic [PosW-1:0]     next_index_q;
  logic [IdxW-1:0]     idx_q;
  logic [DataW-1:0]    chunk_first_q;
  logic [DataW-1:0]    chunk_last_q;
  logic                had_work_q;
  logic                done_q;

  logic                acc;
  logic                get_acc;
  logic                start_acc;
  logic                refill_ok;
  logic                fill_end;
  logic                fill_wr;
  logic                tail_wr;
  logic [RankW-1:0]    rank_raw;
  logic [IdxW-1:0]     rank_idx;
  logic                had;
  logic [IdxW-1:0]     hi_idx;
  logic                hi_found;
  logic [PosW-1:0]     chunk;
  logic [PosW-1:0]     sum;
  logic [DataW-1:0]    new_last;

  // Configuration registers.
  rcwd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Shared divider for every chunk size.
  rcwd_div #(
    .DividendW (PosW),
    .DivisorW  (DevW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (remaining),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // Handshake and sequencer conditions.
  always_comb begin
    busy      = (state_q != ST_IDLE);
    acc       = start && !busy;
    get_acc   = acc && (action_e'(action_i) == ACT_GET);
    start_acc = acc && (action_e'(action_i) == ACT_START);
    refill_ok = (next_index_q <= {1'b0, cfg.range_last});
    fill_end  = !refill_ok;
    div_go    = (get_acc && refill_ok) || ((state_q == ST_FILL_NEXT) && !fill_end);
    fill_wr   = (state_q == ST_FILL_WAIT) && div_stat.done;
    tail_wr   = (state_q == ST_GET_WAIT) && div_stat.done;
    divisor   = (cfg.device_count == '0) ? DevW'(1) : cfg.device_count;
    remaining = {1'b0, cfg.range_last} - next_index_q + PosW'(1);
  end

  // Chunk size of at least one, and the chunk bounds it gives.
  always_comb begin
    chunk    = (quotient == '0) ? PosW'(1) : quotient;
    sum      = next_index_q + chunk;
    new_last = DataW'(sum - PosW'(1));
  end

  // Queue rank of the requesting group, saturated to the last entry.
  always_comb begin
    rank_raw = cfg.rank_map[{group_id_i, 1'b0} +: RankW];
    if (int'(rank_raw) >= int'(NUM_GROUPS)) begin
      rank_idx = IdxW'(NUM_GROUPS - 1);
    end else begin
      rank_idx = IdxW'(rank_raw);
    end
    had = valid_q[rank_idx];
  end

  // Highest set valid flag, cleared when no refill is possible.
  always_comb begin
    hi_idx   = '0;
    hi_found = 1'b0;
    for (int i = 0; i < int'(NUM_GROUPS); i++) begin
      if (valid_q[i]) begin
        hi_idx   = IdxW'(i);
        hi_found = 1'b1;
      end
    end
  end

  // Queue data: shift on a get, fill at the fill index, refill at the tail.
  always_ff @(posedge clk_i) begin
    if (get_acc) begin
      for (int i = 0; i < int'(NUM_GROUPS) - 1; i++) begin
        if (IdxW'(i) >= rank_idx) begin
          qf_q[i] <= qf_q[i+1];
          ql_q[i] <= ql_q[i+1];
        end
      end
    end
    if (fill_wr) begin
      qf_q[idx_q] <= next_index_q[DataW-1:0];
      ql_q[idx_q] <= new_last;
    end
    if (tail_wr) begin
      qf_q[NUM_GROUPS-1] <= next_index_q[DataW-1:0];
      ql_q[NUM_GROUPS-1] <= new_last;
    end
  end

  // Sequencer with valid flags, next index and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      valid_q       <= '0;
      next_index_q  <= '0;
      idx_q         <= '0;
      chunk_first_q <= '0;
      chunk_last_q  <= '0;
      had_work_q    <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (get_acc) begin
            chunk_first_q <= had ? qf_q[rank_idx] : '0;
            chunk_last_q  <= had ? ql_q[rank_idx] : '0;
            had_work_q    <= had;
            done_q        <= 1'b1;
            if (refill_ok) begin
              state_q <= ST_GET_WAIT;
            end else if (hi_found) begin
              valid_q[hi_idx] <= 1'b0;
            end
          end else if (start_acc) begin
            valid_q      <= '0;
            next_index_q <= {1'b0, cfg.range_first};
            idx_q        <= '0;
            state_q      <= ST_FILL_NEXT;
          end
        end
        ST_FILL_NEXT: begin
          if (fill_end) begin
            chunk_first_q <= '0;
            chunk_last_q  <= '0;
            had_work_q    <= 1'b0;
            done_q        <= 1'b1;
            state_q       <= ST_IDLE;
          end else begin
            state_q <= ST_FILL_WAIT;
          end
        end
        ST_FILL_WAIT: begin
          if (div_stat.done) begin
            valid_q[idx_q] <= 1'b1;
            next_index_q   <= sum;
            if (idx_q == IdxW'(NUM_GROUPS - 1)) begin
              chunk_first_q <= '0;
              chunk_last_q  <= '0;
              had_work_q    <= 1'b0;
              done_q        <= 1'b1;
              state_q       <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= ST_FILL_NEXT;
            end
          end
        end
        ST_GET_WAIT: begin
          if (div_stat.done) begin
            next_index_q <= sum;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign chunk_first_o = chunk_first_q;
  assign chunk_last_o  = chunk_last_q;
  assign had_work_o    = had_work_q;
  assign done_o        = done_q;

  // An accepted transaction either answers at once or keeps the block busy.
  `RCWD_ASSERT_NEXT(a_acc_progress, acc, done_o || busy, "accepted transaction stalled")
  // A result without work carries a zero chunk.
  `RCWD_ASSERT_SAME(a_nowork_zero, done_o && !had_work_o,
    (chunk_first_o == '0) && (chunk_last_o == '0), "nonzero chunk without work")
  // The divider only runs while the sequencer waits for it.
  `RCWD_ASSERT_SAME(a_div_owned, div_stat.busy,
    (state_q == ST_FILL_WAIT) || (state_q == ST_GET_WAIT), "divider running while not awaited")
  // No new transaction is taken while the divider is running.
  `RCWD_ASSERT_SAME(a_no_acc_div, div_stat.busy, !acc, "transaction accepted during division")

endmodule

`default_nettype wire
